// ===== sv/point_segment_distance_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Point segment distance unit assertion macros
// Shared helpers for concurrent checks on the unit's ports.
// ----------------------------------------------------------------------------
`ifndef POINT_SEGMENT_DISTANCE_UNIT_MACROS_SVH
`define POINT_SEGMENT_DISTANCE_UNIT_MACROS_SVH

// check a property while out of reset
`define PSD_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// check a property at every edge, reset included
`define PSD_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== sv/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants and types of the point segment distance unit.
// ----------------------------------------------------------------------------
`default_nettype none

package psd_pkg;

  localparam int COORD_BITS_DEF      = 24;
  localparam int PARAM_FRAC_BITS_DEF = 16;

  // where the projection lands on the segment
  typedef struct packed {
    logic is_start;
    logic is_end;
  } psd_mode_t;

endpackage

`default_nettype wire

// ===== sv/psd_setup.sv =====
// ----------------------------------------------------------------------------
// psd_setup
// Differences, products, dot product, squared length and clamp decision.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_setup #(
  parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                en,
  input  wire logic                                valid_i,
  input  wire logic signed [COORD_BITS-1:0]        px_i,
  input  wire logic signed [COORD_BITS-1:0]        py_i,
  input  wire logic signed [COORD_BITS-1:0]        sx_i,
  input  wire logic signed [COORD_BITS-1:0]        sy_i,
  input  wire logic signed [COORD_BITS-1:0]        ex_i,
  input  wire logic signed [COORD_BITS-1:0]        ey_i,
  output logic                                     valid_o,
  output logic signed [COORD_BITS-1:0]             px_o,
  output logic signed [COORD_BITS-1:0]             py_o,
  output logic signed [COORD_BITS-1:0]             sx_o,
  output logic signed [COORD_BITS-1:0]             sy_o,
  output logic signed [COORD_BITS:0]               c_o,
  output logic signed [COORD_BITS:0]               d_o,
  output logic [2*COORD_BITS+1:0]                  r_o,
  output logic [2*COORD_BITS+1:0]                  l_o,
  output psd_pkg::psd_mode_t                       mode_o
);
  import psd_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;
  localparam int LW = 2 * COORD_BITS + 2;
  localparam int SW = 2 * COORD_BITS + 3;

  // stage 1: differences
  logic                         v1_r;
  logic signed [DW-1:0]         a_r, b_r, c1_r, d1_r;
  logic signed [COORD_BITS-1:0] px1_r, py1_r, sx1_r, sy1_r;

  // stage 2: products
  logic                         v2_r;
  logic signed [PW-1:0]         ac_r, bd_r, cc_r, dd_r;
  logic signed [DW-1:0]         c2_r, d2_r;
  logic signed [COORD_BITS-1:0] px2_r, py2_r, sx2_r, sy2_r;

  // stage 3 combinational
  logic signed [SW-1:0] dot_nxt;
  logic [LW-1:0]        len_nxt;
  psd_mode_t            mode_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en) begin
      v1_r    <= valid_i;
      v2_r    <= v1_r;
      valid_o <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r   <= DW'(px_i) - DW'(sx_i);
      b_r   <= DW'(py_i) - DW'(sy_i);
      c1_r  <= DW'(ex_i) - DW'(sx_i);
      d1_r  <= DW'(ey_i) - DW'(sy_i);
      px1_r <= px_i;
      py1_r <= py_i;
      sx1_r <= sx_i;
      sy1_r <= sy_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ac_r  <= a_r * c1_r;
      bd_r  <= b_r * d1_r;
      cc_r  <= c1_r * c1_r;
      dd_r  <= d1_r * d1_r;
      c2_r  <= c1_r;
      d2_r  <= d1_r;
      px2_r <= px1_r;
      py2_r <= py1_r;
      sx2_r <= sx1_r;
      sy2_r <= sy1_r;
    end
  end

  always_comb begin
    dot_nxt          = SW'(ac_r) + SW'(bd_r);
    len_nxt          = LW'(unsigned'(cc_r)) + LW'(unsigned'(dd_r));
    mode_nxt.is_start = (len_nxt == '0) || dot_nxt[SW-1];
    mode_nxt.is_end   = !mode_nxt.is_start && (dot_nxt[LW-1:0] >= len_nxt);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // remainder starts at dot only inside the segment
      r_o    <= (mode_nxt.is_start || mode_nxt.is_end) ? '0 : dot_nxt[LW-1:0];
      l_o    <= len_nxt;
      mode_o <= mode_nxt;
      c_o    <= c2_r;
      d_o    <= d2_r;
      px_o   <= px2_r;
      py_o   <= py2_r;
      sx_o   <= sx2_r;
      sy_o   <= sy2_r;
    end
  end

endmodule

`default_nettype wire

// ===== sv/psd_div.sv =====
// ----------------------------------------------------------------------------
// psd_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_div #(
  parameter int COORD_BITS      = psd_pkg::COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = psd_pkg::PARAM_FRAC_BITS_DEF,
  parameter int SIDE_W          = 8
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       valid_i,
  input  wire logic [2*COORD_BITS+1:0]    r_i,
  input  wire logic [2*COORD_BITS+1:0]    l_i,
  input  wire logic [SIDE_W-1:0]          side_i,
  output logic                            valid_o,
  output logic [PARAM_FRAC_BITS-1:0]      q_o,
  output logic [SIDE_W-1:0]               side_o
);
  import psd_pkg::*;

  localparam int LW = 2 * COORD_BITS + 2;
  localparam int NS = PARAM_FRAC_BITS;

  logic                 v_r    [NS];
  logic [LW-1:0]        r_r    [NS];
  logic [LW-1:0]        l_r    [NS];
  logic [NS-1:0]        q_r    [NS];
  logic [SIDE_W-1:0]    side_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_st
    logic              v_in;
    logic [LW-1:0]     r_in, l_in;
    logic [NS-1:0]     q_in;
    logic [SIDE_W-1:0] side_in;
    logic [LW:0]       r_sh, r_dif;
    logic              take;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign r_in    = r_i;
      assign l_in    = l_i;
      assign q_in    = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_r[s-1];
      assign r_in    = r_r[s-1];
      assign l_in    = l_r[s-1];
      assign q_in    = q_r[s-1];
      assign side_in = side_r[s-1];
    end

    assign r_sh  = {r_in, 1'b0};
    assign take  = r_sh >= {1'b0, l_in};
    assign r_dif = r_sh - {1'b0, l_in};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[s]    <= take ? r_dif[LW-1:0] : r_sh[LW-1:0];
        l_r[s]    <= l_in;
        q_r[s]    <= {q_in[NS-2:0], take};
        side_r[s] <= side_in;
      end
    end
  end

  assign valid_o = v_r[NS-1];
  assign q_o     = q_r[NS-1];
  assign side_o  = side_r[NS-1];

endmodule

`default_nettype wire

// ===== sv/psd_interp.sv =====
// ----------------------------------------------------------------------------
// psd_interp
// Closest point from the clamped parameter, then squared distance to it.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_interp #(
  parameter int COORD_BITS      = psd_pkg::COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = psd_pkg::PARAM_FRAC_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          valid_i,
  input  wire logic [PARAM_FRAC_BITS-1:0]    q_i,
  input  wire psd_pkg::psd_mode_t            mode_i,
  input  wire logic signed [COORD_BITS-1:0]  px_i,
  input  wire logic signed [COORD_BITS-1:0]  py_i,
  input  wire logic signed [COORD_BITS-1:0]  sx_i,
  input  wire logic signed [COORD_BITS-1:0]  sy_i,
  input  wire logic signed [COORD_BITS:0]    c_i,
  input  wire logic signed [COORD_BITS:0]    d_i,
  output logic                               valid_o,
  output logic [2*COORD_BITS+1:0]            n_o,
  output logic [COORD_BITS-1:0]              qx_o,
  output logic [COORD_BITS-1:0]              qy_o
);
  import psd_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int PF = PARAM_FRAC_BITS;
  localparam int QW = PF + 2;
  localparam int PW = PF + CB + 3;
  localparam int LW = 2 * CB + 2;
  localparam logic signed [PW-1:0] HALF = PW'(1) << (PF - 1);
  localparam logic signed [QW-1:0] ONE  = QW'(1) << PF;

  logic v1_r, v2_r, v3_r;

  // stage 1: parameter times direction
  logic signed [QW-1:0] qf;
  logic signed [PW-1:0] prodx_r, prody_r;
  logic signed [CB-1:0] px1_r, py1_r, sx1_r, sy1_r;

  // stage 2: closest point
  logic signed [PW-1:0] offx, offy;
  logic signed [CB-1:0] qx2_r, qy2_r, px2_r, py2_r;

  // stage 3: squares
  logic signed [CB:0]   dx, dy;
  logic signed [LW-1:0] sqx_r, sqy_r;
  logic [CB-1:0]        qx3_r, qy3_r;

  always_comb begin
    if (mode_i.is_end) begin
      qf = ONE;
    end else if (mode_i.is_start) begin
      qf = '0;
    end else begin
      qf = QW'(q_i);
    end
    offx = (prodx_r + HALF) >>> PF;
    offy = (prody_r + HALF) >>> PF;
    dx   = (CB+1)'(px2_r) - (CB+1)'(qx2_r);
    dy   = (CB+1)'(py2_r) - (CB+1)'(qy2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      valid_o <= 1'b0;
    end else if (en) begin
      v1_r    <= valid_i;
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      valid_o <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prodx_r <= qf * PW'(c_i);
      prody_r <= qf * PW'(d_i);
      px1_r   <= px_i;
      py1_r   <= py_i;
      sx1_r   <= sx_i;
      sy1_r   <= sy_i;

      // offset lies between zero and the direction, so the sum stays in range
      qx2_r <= sx1_r + offx[CB-1:0];
      qy2_r <= sy1_r + offy[CB-1:0];
      px2_r <= px1_r;
      py2_r <= py1_r;

      sqx_r <= dx * dx;
      sqy_r <= dy * dy;
      qx3_r <= qx2_r;
      qy3_r <= qy2_r;

      n_o  <= unsigned'(sqx_r) + unsigned'(sqy_r);
      qx_o <= qx3_r;
      qy_o <= qy3_r;
    end
  end

endmodule

`default_nettype wire

// ===== sv/psd_sqrt.sv =====
// ----------------------------------------------------------------------------
// psd_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module psd_sqrt #(
  parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF,
  parameter int SIDE_W     = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     valid_i,
  input  wire logic [2*COORD_BITS+1:0]  n_i,
  input  wire logic [SIDE_W-1:0]        side_i,
  output logic                          valid_o,
  output logic [COORD_BITS:0]           root_o,
  output logic [SIDE_W-1:0]             side_o
);
  import psd_pkg::*;

  localparam int NW = 2 * COORD_BITS + 2;
  localparam int RB = COORD_BITS + 1;
  localparam int RW = COORD_BITS + 4;

  logic              v_r    [RB];
  logic [NW-1:0]     n_r    [RB];
  logic [RW-1:0]     rem_r  [RB];
  logic [RB-1:0]     root_r [RB];
  logic [SIDE_W-1:0] side_r [RB];

  for (genvar k = 0; k < RB; k++) begin : g_st
    logic              v_in;
    logic [NW-1:0]     n_in;
    logic [RW-1:0]     rem_in, rem_sh, trial;
    logic [RB-1:0]     root_in;
    logic [SIDE_W-1:0] side_in;
    logic              take;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign n_in    = n_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign n_in    = n_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign rem_sh = {rem_in[RW-3:0], n_in[NW-1 -: 2]};
    assign trial  = RW'({root_in, 2'b01});
    assign take   = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k]    <= {n_in[NW-3:0], 2'b00};
        rem_r[k]  <= take ? (rem_sh - trial) : rem_sh;
        root_r[k] <= {root_in[RB-2:0], take};
        side_r[k] <= side_in;
      end
    end
  end

  assign valid_o = v_r[RB-1];
  assign root_o  = root_r[RB-1];
  assign side_o  = side_r[RB-1];

endmodule

`default_nettype wire

// ===== sv/point_segment_distance_unit.sv =====
// ----------------------------------------------------------------------------
// point_segment_distance_unit
// Closest point on a 2D segment to a query point, and the distance to it.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats arrive on in_tvalid/in_tready/in_tdata; each carries a query
//   point and a segment start and end, all signed with COORD_BITS bits.
//   Result beats leave on out_tvalid/out_tready/out_tdata with the distance
//   (floor of the exact root) and the closest point on the segment.
//   A beat is taken when tvalid and tready are both high at a clock edge.
//   Throughput: one beat per cycle, sustained, as long as results drain.
//   Pipeline: 3 setup stages, one divider stage per parameter bit,
//   4 interpolation stages, one square root stage per result bit and the
//   output register.
//   Reset (rst_n low at a clock edge) drops every beat in flight.
//   When the receiver stalls, the output register holds its beat and a skid
//   register catches the one beat still leaving the pipeline; while the
//   skid holds a beat the whole pipeline freezes and in_tready is low.
//   in_tready is a register output and does not depend on out_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module point_segment_distance_unit #(
  parameter int COORD_BITS      = psd_pkg::COORD_BITS_DEF,
  parameter int PARAM_FRAC_BITS = psd_pkg::PARAM_FRAC_BITS_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst_n,
  input  wire logic                                     in_tvalid,
  output logic                                          in_tready,
  // point_x, point_y, start_x, start_y, end_x, end_y (lowest first)
  input  wire logic [((6*COORD_BITS+7)/8)*8-1:0]        in_tdata,
  output logic                                          out_tvalid,
  input  wire logic                                     out_tready,
  // distance, closest_x, closest_y (lowest first)
  output logic [((3*COORD_BITS+8)/8)*8-1:0]             out_tdata
);
  import psd_pkg::*;

  localparam int CB     = COORD_BITS;
  localparam int OUT_W  = ((3*COORD_BITS+8)/8)*8;
  localparam int MODE_W = $bits(psd_mode_t);
  localparam int DSIDE  = 4*CB + 2*(CB+1) + MODE_W;
  localparam int QSIDE  = 2*CB;
  localparam int LW     = 2*CB + 2;

  logic en;

  // setup outputs
  logic                 su_valid;
  logic signed [CB-1:0] su_px, su_py, su_sx, su_sy;
  logic signed [CB:0]   su_c, su_d;
  logic [LW-1:0]        su_r, su_l;
  psd_mode_t            su_mode;

  // divider outputs
  logic                      dv_valid;
  logic [PARAM_FRAC_BITS-1:0] dv_q;
  logic [DSIDE-1:0]          dv_side_in, dv_side;
  psd_mode_t                 dv_mode;
  logic signed [CB-1:0]      dv_px, dv_py, dv_sx, dv_sy;
  logic signed [CB:0]        dv_c, dv_d;

  // interpolation outputs
  logic          ip_valid;
  logic [LW-1:0] ip_n;
  logic [CB-1:0] ip_qx, ip_qy;

  // square root outputs
  logic             sq_valid;
  logic [CB:0]      sq_root;
  logic [QSIDE-1:0] sq_side;

  // output and skid registers
  logic              out_v_r, skid_v_r;
  logic [3*CB:0]     out_r, skid_r;
  logic [3*CB:0]     res_nxt;
  logic              out_fire;

  // freeze everything while the skid holds a beat
  assign en        = !skid_v_r;
  assign in_tready = !skid_v_r;

  psd_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (in_tvalid),
    .px_i    (in_tdata[0*CB +: CB]),
    .py_i    (in_tdata[1*CB +: CB]),
    .sx_i    (in_tdata[2*CB +: CB]),
    .sy_i    (in_tdata[3*CB +: CB]),
    .ex_i    (in_tdata[4*CB +: CB]),
    .ey_i    (in_tdata[5*CB +: CB]),
    .valid_o (su_valid),
    .px_o    (su_px),
    .py_o    (su_py),
    .sx_o    (su_sx),
    .sy_o    (su_sy),
    .c_o     (su_c),
    .d_o     (su_d),
    .r_o     (su_r),
    .l_o     (su_l),
    .mode_o  (su_mode)
  );

  // carry the operands past the divider
  assign dv_side_in = {su_mode, su_d, su_c, su_sy, su_sx, su_py, su_px};

  psd_div #(
    .COORD_BITS      (COORD_BITS),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS),
    .SIDE_W          (DSIDE)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (su_valid),
    .r_i     (su_r),
    .l_i     (su_l),
    .side_i  (dv_side_in),
    .valid_o (dv_valid),
    .q_o     (dv_q),
    .side_o  (dv_side)
  );

  assign {dv_mode, dv_d, dv_c, dv_sy, dv_sx, dv_py, dv_px} = dv_side;

  psd_interp #(
    .COORD_BITS      (COORD_BITS),
    .PARAM_FRAC_BITS (PARAM_FRAC_BITS)
  ) u_interp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (dv_valid),
    .q_i     (dv_q),
    .mode_i  (dv_mode),
    .px_i    (dv_px),
    .py_i    (dv_py),
    .sx_i    (dv_sx),
    .sy_i    (dv_sy),
    .c_i     (dv_c),
    .d_i     (dv_d),
    .valid_o (ip_valid),
    .n_o     (ip_n),
    .qx_o    (ip_qx),
    .qy_o    (ip_qy)
  );

  psd_sqrt #(
    .COORD_BITS (COORD_BITS),
    .SIDE_W     (QSIDE)
  ) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .valid_i (ip_valid),
    .n_i     (ip_n),
    .side_i  ({ip_qy, ip_qx}),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  assign res_nxt  = {sq_side, sq_root};
  assign out_fire = out_v_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      // pipeline frozen: drain the skid into the output register
      if (out_fire) begin
        skid_v_r <= 1'b0;
      end
    end else if (sq_valid) begin
      if (!out_v_r || out_fire) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_fire) begin
        out_r <= skid_r;
      end
    end else if (sq_valid) begin
      if (!out_v_r || out_fire) begin
        out_r <= res_nxt;
      end else begin
        skid_r <= res_nxt;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_W'(out_r);

endmodule

`default_nettype wire

// ===== sv/psd_checker.sv =====
// ----------------------------------------------------------------------------
// psd_checker
// Port level checks of the point segment distance unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "point_segment_distance_unit_macros.svh"

module psd_checker #(
  parameter int COORD_BITS = psd_pkg::COORD_BITS_DEF
) (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_tvalid,
  input wire logic                                 in_tready,
  input wire logic                                 out_tvalid,
  input wire logic                                 out_tready,
  input wire logic [((3*COORD_BITS+8)/8)*8-1:0]    out_tdata
);
  import psd_pkg::*;

  // stalled result stays offered
  `PSD_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result beat dropped")

  // stalled result keeps its data
  `PSD_ASSERT(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata), "result data changed")

  // input side closes only after an output stall
  `PSD_ASSERT(a_ready_fall, clk, rst_n, $fell(in_tready) |-> $past(out_tvalid && !out_tready), "ready fell without stall")

  // back pressure only while a result waits
  `PSD_ASSERT(a_ready_low, clk, rst_n, !in_tready |-> out_tvalid, "ready low with no result pending")

  // reset empties the output and opens the input
  `PSD_ASSERT_ALWAYS(a_reset, clk, !rst_n |=> !out_tvalid && in_tready, "reset left state behind")

endmodule

bind point_segment_distance_unit psd_checker #(
  .COORD_BITS (COORD_BITS)
) u_psd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

// ===== dv/point_segment_distance_unit_test.sv =====
// ----------------------------------------------------------------------------
// point_segment_distance_unit_test
// Drives point/segment beats into the unit, predicts the closest point and
// distance for each accepted beat, and checks every result beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class closest_point_board;
  logic [23:0] cx_q[$];
  logic [23:0] cy_q[$];
  logic [24:0] dst_q[$];
  int errors;

  function new();
    errors = 0;
  endfunction

  static function longint sx24(logic [23:0] v);
    return longint'($signed(v));
  endfunction

  static function longint floor16(longint v);
    return v >>> 16;
  endfunction

  static function longint root_floor(longint unsigned n);
    longint unsigned res;
    longint unsigned bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  // project the point onto the segment and queue the expected beat
  function void note_input(logic [143:0] d);
    longint px, py, sx, sy, ex, ey, a, b, c, e, dot, lsq, qx, qy, dx, dy;
    longint unsigned r, q;
    px = sx24(d[23:0]);   py = sx24(d[47:24]);
    sx = sx24(d[71:48]);  sy = sx24(d[95:72]);
    ex = sx24(d[119:96]); ey = sx24(d[143:120]);
    a = px - sx; b = py - sy; c = ex - sx; e = ey - sy;
    dot = a * c + b * e;
    lsq = c * c + e * e;
    if (lsq == 0 || dot < 0) begin
      qx = sx; qy = sy;
    end else if (dot >= lsq) begin
      qx = ex; qy = ey;
    end else begin
      r = dot; q = 0;
      for (int i = 0; i < 16; i++) begin
        r <<= 1; q <<= 1;
        if (r >= longint'(lsq)) begin
          r -= lsq; q |= 1;
        end
      end
      qx = sx + floor16(longint'(q) * c + 32768);
      qy = sy + floor16(longint'(q) * e + 32768);
    end
    dx = px - qx; dy = py - qy;
    dst_q.push_back(25'(root_floor(longint'(dx * dx) + longint'(dy * dy))));
    cx_q.push_back(qx[23:0]);
    cy_q.push_back(qy[23:0]);
  endfunction

  function void report(string what, longint got, longint want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endfunction

  function void check_result(logic [79:0] d);
    if (dst_q.size() == 0) begin
      report("unexpected beat", longint'(d[24:0]), 0);
      return;
    end
    if (d[24:0] !== dst_q[0]) report("distance", d[24:0], dst_q[0]);
    if (d[48:25] !== cx_q[0]) report("closest_x", d[48:25], cx_q[0]);
    if (d[72:49] !== cy_q[0]) report("closest_y", d[72:49], cy_q[0]);
    void'(dst_q.pop_front()); void'(cx_q.pop_front()); void'(cy_q.pop_front());
  endfunction

  function int pending();
    return dst_q.size();
  endfunction
endclass

module point_segment_distance_unit_test;
  localparam int LATENCY = 49;
  localparam int N_RANDOM = 850;
  localparam longint LIMIT = 400000;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready;
  logic [143:0] in_tdata;
  logic [79:0] out_tdata;
  logic no_idle, hold_long;
  longint cycle = 0;
  closest_point_board board;

  point_segment_distance_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst_n && in_tvalid && in_tready) board.note_input(in_tdata);
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
    if (cycle > LIMIT) begin
      $display("point_segment_distance_unit verification failed");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    logic long_done;
    long_done = 0;
    out_tready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long && !long_done) begin
        out_tready <= 0;
        repeat (300) @(negedge clk);
        long_done = 1;
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        out_tready <= 0;
        repeat ($urandom_range(1, 14) - 1) @(negedge clk);
      end else begin
        out_tready <= 1;
      end
    end
  end

  function automatic logic [23:0] pick_coord(int mode);
    case (mode)
      0: return 24'h800000;
      1: return 24'h7fffff;
      2: return 24'($signed($urandom_range(0, 2000)) - 1000);
      default: return 24'($urandom());
    endcase
  endfunction

  // hold one beat until accepted; random gaps before it
  task automatic send_beat(logic [143:0] d);
    if (!no_idle && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_pts(logic [23:0] px, py, sx, sy, ex, ey);
    send_beat({ey, ex, sy, sx, py, px});
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  initial begin
    logic [23:0] c[6];
    int m;
    board = new();
    no_idle = 0; hold_long = 0;
    rst_n = 0; in_tvalid = 0; in_tdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: zero-length, before start, past end, exactly at end, extremes
    send_pts(24'd100, 24'd200, 24'd5, 24'd5, 24'd5, 24'd5);
    send_pts(-24'sd300, 24'd0, 24'd0, 24'd0, 24'd256, 24'd0);
    send_pts(24'd900, 24'd50, 24'd0, 24'd0, 24'd256, 24'd0);
    send_pts(24'd256, 24'd77, 24'd0, 24'd0, 24'd256, 24'd0);
    send_pts(24'd128, 24'd999, 24'd0, 24'd0, 24'd256, 24'd256);
    send_pts(24'd3, 24'd1, 24'd0, 24'd0, 24'd7, 24'd3);
    send_pts(24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff);
    send_pts(24'h7fffff, 24'h7fffff, 24'h800000, 24'h800000, 24'h800000, 24'h800000);
    send_pts(24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000);
    send_pts(24'h800000, 24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff, 24'h7fffff);
    send_pts(24'h000000, 24'h000000, 24'h800000, 24'h7fffff, 24'h7fffff, 24'h800000);
    send_pts(24'hffffff, 24'hffffff, 24'h000000, 24'h000000, 24'hffffff, 24'h000001);
    send_beat({144{1'b1}});
    send_beat('0);

    // pause until every result is out
    drain();
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 200) hold_long = 1;
      if (n == 500) drain();
      if (n == 700) no_idle = 1;
      m = $urandom_range(0, 9);
      for (int k = 0; k < 6; k++)
        c[k] = pick_coord(m < 5 ? 2 : (m < 8 ? 3 : $urandom_range(0, 3)));
      if ($urandom_range(0, 19) == 0) begin
        c[4] = c[2]; c[5] = c[3];
      end
      send_pts(c[0], c[1], c[2], c[3], c[4], c[5]);
    end
    drain();
    repeat (LATENCY + 10) @(negedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("point_segment_distance_unit verification clean");
    end else begin
      $display("point_segment_distance_unit verification failed");
    end
    $finish;
  end
endmodule

// ===== point_segment_distance_unit.f =====
+incdir+sv
sv/psd_pkg.sv
sv/psd_setup.sv
sv/psd_div.sv
sv/psd_interp.sv
sv/psd_sqrt.sv
sv/point_segment_distance_unit.sv
sv/psd_checker.sv
dv/point_segment_distance_unit_test.sv
